@@ design/ios_pkg.sv @@
// ----------------------------------------------------------------------------
// ios_pkg: shared types and constants for the integer operand stack
// Request codes, word structs and the command set of the stack cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package ios_pkg;

  localparam int MAX_DEPTH = 16;
  localparam int DEPTH_W   = $clog2(MAX_DEPTH + 1);
  localparam int CAP_W     = 5;
  localparam int COUNT_W   = 5;
  localparam int DATA_W    = 32;
  // common width for count versus capacity compares
  localparam int CMP_W     = (DEPTH_W > CAP_W) ? DEPTH_W : CAP_W;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  localparam logic [2:0] REQ_PUSH = 3'd0;
  localparam logic [2:0] REQ_POP  = 3'd1;
  localparam logic [2:0] REQ_TOP  = 3'd2;
  localparam logic [2:0] REQ_DUP  = 3'd3;
  localparam logic [2:0] REQ_SWAP = 3'd4;
  localparam logic [2:0] REQ_ADD  = 3'd5;

  typedef struct packed {
    logic [2:0]               req_type;
    logic signed [DATA_W-1:0] push_value;
  } in_word_t;

  typedef struct packed {
    logic                     ok;
    logic signed [DATA_W-1:0] read_value;
    logic [COUNT_W-1:0]       count;
  } out_word_t;

  // whole-chain operation issued by the controller
  typedef enum logic [2:0] {
    CH_HOLD,
    CH_PUSH,
    CH_DUP,
    CH_POP,
    CH_SWAP,
    CH_ADD
  } chain_op_e;

  // per-cell command
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_PREV,
    CELL_NEXT,
    CELL_ADD
  } cell_cmd_e;

  // cell 0 is top of stack, cell 1 the entry below it
  function automatic cell_cmd_e cell_cmd(chain_op_e op, logic is_top, logic is_second);
    cell_cmd_e cmd;
    cmd = CELL_HOLD;
    case (op)
      CH_PUSH, CH_DUP: cmd = CELL_PREV;
      CH_POP:          cmd = CELL_NEXT;
      CH_SWAP: begin
        if (is_top) cmd = CELL_NEXT;
        else if (is_second) cmd = CELL_PREV;
        else cmd = CELL_HOLD;
      end
      CH_ADD:          cmd = is_top ? CELL_ADD : CELL_NEXT;
      default:         cmd = CELL_HOLD;
    endcase
    return cmd;
  endfunction

endpackage

`default_nettype wire

@@ design/ios_cell.sv @@
// ----------------------------------------------------------------------------
// ios_cell: one stack entry
// Holds one value and takes its neighbor's, or the sum with the one below.
// ----------------------------------------------------------------------------
`default_nettype none

module ios_cell
  import ios_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire cell_cmd_e                cmd_i,
  input  wire logic signed [DATA_W-1:0] prev_i,
  input  wire logic signed [DATA_W-1:0] next_i,
  output logic signed [DATA_W-1:0]      data_o
);

  logic signed [DATA_W-1:0] data_q, data_d;

  always_comb begin
    case (cmd_i)
      CELL_PREV: data_d = prev_i;
      CELL_NEXT: data_d = next_i;
      CELL_ADD:  data_d = data_q + next_i;
      default:   data_d = data_q;
    endcase
  end

  // contents are undefined until written
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

@@ design/ios_ctrl.sv @@
// ----------------------------------------------------------------------------
// ios_ctrl: request decode, entry count, capacity and result register
// Checks each request against the count and drives the cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

module ios_ctrl
  import ios_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire in_word_t                 in_data_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output out_word_t                     out_data_o,
  input  wire logic                     cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire logic [CAP_W-1:0]         cfg_data_i,
  input  wire logic signed [DATA_W-1:0] top_i,
  output chain_op_e                     op_o
);

  logic [CAP_W-1:0]   capacity_q;
  logic [DEPTH_W-1:0] depth_q, depth_d;
  logic               out_valid_q;
  out_word_t          out_data_q, out_data_d;
  logic               fire;
  logic               has_one, has_two, can_push;
  logic               ok;
  chain_op_e          op;
  logic [CMP_W-1:0]   depth_ext;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign fire        = in_valid_i && in_ready_o;

  assign has_one  = depth_q != '0;
  assign has_two  = depth_q > DEPTH_W'(1);
  // effective capacity is min(capacity, MAX_DEPTH)
  assign can_push = (depth_q < DEPTH_W'(MAX_DEPTH)) &&
                    (CMP_W'(depth_q) < CMP_W'(capacity_q));

  always_comb begin
    ok = 1'b0;
    op = CH_HOLD;
    case (in_data_i.req_type)
      REQ_PUSH: begin
        ok = can_push;
        op = can_push ? CH_PUSH : CH_HOLD;
      end
      REQ_POP: begin
        ok = has_one;
        op = has_one ? CH_POP : CH_HOLD;
      end
      REQ_TOP: begin
        ok = has_one;
      end
      REQ_DUP: begin
        ok = has_one && can_push;
        op = ok ? CH_DUP : CH_HOLD;
      end
      REQ_SWAP: begin
        ok = has_two;
        op = has_two ? CH_SWAP : CH_HOLD;
      end
      REQ_ADD: begin
        ok = has_two;
        op = has_two ? CH_ADD : CH_HOLD;
      end
      default: begin
        ok = 1'b0;
        op = CH_HOLD;
      end
    endcase
  end

  always_comb begin
    case (op)
      CH_PUSH, CH_DUP: depth_d = depth_q + DEPTH_W'(1);
      CH_POP, CH_ADD:  depth_d = depth_q - DEPTH_W'(1);
      default:         depth_d = depth_q;
    endcase
  end

  assign depth_ext = CMP_W'(depth_d);

  always_comb begin
    out_data_d.ok         = ok;
    out_data_d.read_value = (ok && (in_data_i.req_type == REQ_POP ||
                                    in_data_i.req_type == REQ_TOP)) ? top_i : '0;
    out_data_d.count      = depth_ext[COUNT_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q  <= CAP_RESET;
      depth_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) capacity_q <= cfg_data_i;
      if (fire) begin
        depth_q     <= depth_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) out_data_q <= out_data_d;
  end

  assign op_o        = fire ? op : CH_HOLD;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

@@ design/integer_operand_stack.sv @@
// Integer operand stack, a row of entry cells with the top of stack in cell 0.
// Latency: a result word is valid the cycle after its request word is taken.
// Throughput: one request word per cycle while no result word is stalled; swap
// touches cells 0 and 1 only; push, dup, pop, add shift one place at once.
// Reset: asynchronous, active low; count 0, capacity 16, result register empty.
// Entry contents are not cleared; an entry is read only after it is written.
// ----------------------------------------------------------------------------
// integer_operand_stack: bounded LIFO of 32-bit signed integers
// Push, pop, top, dup, swap and add over a shifting chain of cells.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_operand_stack
  import ios_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire in_word_t         in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output out_word_t             out_data_o,
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic [CAP_W-1:0] cfg_data_i
);

  chain_op_e                op;
  logic signed [DATA_W-1:0] cell_data [MAX_DEPTH];
  logic signed [DATA_W-1:0] cell_prev [MAX_DEPTH];
  logic signed [DATA_W-1:0] cell_next [MAX_DEPTH];

  ios_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .top_i       (cell_data[0]),
    .op_o        (op)
  );

  // dup feeds the top cell its own value
  assign cell_prev[0] = (op == CH_DUP) ? cell_data[0] : in_data_i.push_value;
  assign cell_next[MAX_DEPTH-1] = '0;

  for (genvar i = 0; i < MAX_DEPTH; i++) begin : g_cell
    if (i > 0) begin : g_prev
      assign cell_prev[i] = cell_data[i-1];
    end
    if (i < MAX_DEPTH - 1) begin : g_next
      assign cell_next[i] = cell_data[i+1];
    end

    ios_cell u_cell (
      .clk_i  (clk_i),
      .cmd_i  (cell_cmd(op, i == 0, i == 1)),
      .prev_i (cell_prev[i]),
      .next_i (cell_next[i]),
      .data_o (cell_data[i])
    );
  end

endmodule

`default_nettype wire

@@ design/ios_checker.sv @@
// ----------------------------------------------------------------------------
// ios_checker: port-level checks for the integer operand stack
// Watches handshakes and result words; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ios_checker
  import ios_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_ready_o,
  input wire logic      out_valid_o,
  input wire logic      out_ready_i,
  input wire out_word_t out_data_o
);

  // a taken request always yields a result word next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> out_valid_o)
    else $error("no result word after accepted request");

  // requests stall only behind an untaken result word
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without pending result");

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("result word changed while stalled");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (COUNT_W'(out_data_o.count) <= COUNT_W'(MAX_DEPTH) ||
                     MAX_DEPTH > 31))
    else $error("count above stack depth");

  // a refused request reports a zero value
  a_refused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.ok) |-> (out_data_o.read_value == '0))
    else $error("refused request returned a value");

endmodule

bind integer_operand_stack ios_checker u_ios_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
